[src/assert_macros.svh]
// Assertion macros included by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/sm2mm_pkg.sv]
// Package with the moduli, constants and pipeline types of the SM2 Montgomery multiplier.
`timescale 1ns / 1ps
package sm2mm_pkg;

    // Operand and accumulator widths.
    localparam int OP_W   = 256;
    localparam int WORD_W = 32;
    localparam int ACC_W  = 290;
    localparam int ROUNDS = OP_W / WORD_W;

    // Cycles from an accepted request to its result strobe.
    localparam int LATENCY = 1 + 3 * ROUNDS + 2;

    // Action codes.
    localparam logic [1:0] ACT_MUL_P = 2'd0;
    localparam logic [1:0] ACT_SQR_P = 2'd1;
    localparam logic [1:0] ACT_MUL_N = 2'd2;

    // SM2 field prime and group order.
    localparam logic [OP_W-1:0] MOD_P =
        256'hFFFFFFFEFFFFFFFF_FFFFFFFFFFFFFFFF_FFFFFFFF00000000_FFFFFFFFFFFFFFFF;
    localparam logic [OP_W-1:0] MOD_N =
        256'hFFFFFFFEFFFFFFFF_FFFFFFFFFFFFFFFF_7203DF6B21C6052B_53BBF40939D54123;

    // Negated inverse of an odd word modulo 2^32, by Newton iteration.
    function automatic logic [WORD_W-1:0] neg_inv32(input logic [WORD_W-1:0] m0);
        logic [WORD_W-1:0] inv;
        inv = m0;
        for (int k = 0; k < 5; k++) begin
            inv = inv * (32'd2 - m0 * inv);
        end
        return 32'd0 - inv;
    endfunction

    localparam logic [WORD_W-1:0] MINV_P = neg_inv32(MOD_P[WORD_W-1:0]);
    localparam logic [WORD_W-1:0] MINV_N = neg_inv32(MOD_N[WORD_W-1:0]);

    // One request as it travels through the reduction rounds.
    typedef struct packed {
        logic [OP_W-1:0]  x;
        logic [OP_W-1:0]  y;
        logic             n_sel;
        logic [ACC_W-1:0] acc;
    } t_item;

endpackage

[src/sm2mm_round.sv]
// One 32-bit Montgomery round: multiply-accumulate, quotient word, and reduce-shift stages.
`timescale 1ns / 1ps
module sm2mm_round (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  sm2mm_pkg::t_item   i_item,
    output logic               o_valid,
    output sm2mm_pkg::t_item   o_item
);
    import sm2mm_pkg::*;

    logic              r_vp, r_vq, r_vr;
    t_item             r_ip, r_iq, r_ir;
    logic [WORD_W-1:0] r_q;

    t_item             n_ip, n_ir;
    logic [WORD_W-1:0] n_q;
    logic [OP_W-1:0]   ev_p, od_p, ev_r, od_r;
    logic [OP_W-1:0]   m_sel;
    logic [ACC_W-1:0]  sum_r;

    // Stage one: add x times the current y word into the accumulator.
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            ev_p[64*j +: 64] = 64'(i_item.x[64*j +: 32]) * 64'(i_item.y[WORD_W-1:0]);
            od_p[64*j +: 64] = 64'(i_item.x[64*j+32 +: 32]) * 64'(i_item.y[WORD_W-1:0]);
        end
        n_ip       = i_item;
        n_ip.y     = i_item.y >> WORD_W;
        n_ip.acc   = i_item.acc + ACC_W'(ev_p) + (ACC_W'(od_p) << WORD_W);
    end

    // Stage two: quotient word that clears the low accumulator word.
    assign n_q = r_ip.acc[WORD_W-1:0] * (r_ip.n_sel ? MINV_N : MINV_P);

    // Stage three: add q times the modulus and drop the cleared word.
    assign m_sel = r_iq.n_sel ? MOD_N : MOD_P;
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            ev_r[64*j +: 64] = 64'(m_sel[64*j +: 32]) * 64'(r_q);
            od_r[64*j +: 64] = 64'(m_sel[64*j+32 +: 32]) * 64'(r_q);
        end
        sum_r    = r_iq.acc + ACC_W'(ev_r) + (ACC_W'(od_r) << WORD_W);
        n_ir     = r_iq;
        n_ir.acc = sum_r >> WORD_W;
    end

    // Valid bits of the three stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= 1'b0;
            r_vq <= 1'b0;
            r_vr <= 1'b0;
        end else begin
            r_vp <= i_valid;
            r_vq <= r_vp;
            r_vr <= r_vq;
        end
    end

    // Payload of the three stages.
    always_ff @(posedge i_clk) begin
        r_ip <= n_ip;
        r_iq <= r_ip;
        r_q  <= n_q;
        r_ir <= n_ir;
    end

    assign o_valid = r_vr;
    assign o_item  = r_ir;

endmodule

[src/sm2mm_final.sv]
// Final corrections that bring the reduced value below the modulus.
`timescale 1ns / 1ps
module sm2mm_final (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic                                i_n_sel,
    input  logic [sm2mm_pkg::ACC_W-1:0]         i_acc,
    output logic                                o_valid,
    output logic [sm2mm_pkg::OP_W-1:0]          o_result
);
    import sm2mm_pkg::*;

    logic            r_v1, r_v2, r_sel1;
    logic [OP_W-1:0] r_res1, r_res2;
    logic [OP_W-1:0] n_res1, n_res2, m1, m2;
    logic [OP_W:0]   diff;

    // First correction: subtract the modulus when bit 256 is set.
    assign m1     = i_n_sel ? MOD_N : MOD_P;
    assign n_res1 = i_acc[OP_W] ? (i_acc[OP_W-1:0] - m1) : i_acc[OP_W-1:0];

    // Second correction: subtract once more when the value is still at least m.
    assign m2     = r_sel1 ? MOD_N : MOD_P;
    assign diff   = {1'b0, r_res1} - {1'b0, m2};
    assign n_res2 = diff[OP_W] ? r_res1 : diff[OP_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res1 <= n_res1;
        r_sel1 <= i_n_sel;
        r_res2 <= n_res2;
    end

    assign o_valid  = r_v2;
    assign o_result = r_res2;

endmodule

[src/sm2_montgomery_multiplier.sv]
// Top level of the pipelined SM2 256-bit Montgomery multiplier.
`timescale 1ns / 1ps
// Usage:
// A request is taken at a rising edge where start is high and busy is low.
// busy is always low, so a new request may be issued in every cycle.
// i_action selects multiply mod p (0), square mod p (1) or multiply mod n (2);
// code 3 acts as multiply mod n, and squaring ignores the y limbs.
// The result x*y*2^-256 mod m appears on o_r_limb0..3 for exactly one cycle,
// marked by o_valid.
// The pipeline consists of one input register, eight 32-bit Montgomery rounds of
// three stages each (multiply-accumulate, quotient word, reduce and shift),
// and two correction stages.
// Throughput is one request per cycle; results leave in request order.
// Synchronous reset clears all valid bits, dropping requests in flight.
// The receiver cannot stall, so results are never held back.
module sm2_montgomery_multiplier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [63:0] i_x_limb0,
    input  logic [63:0] i_x_limb1,
    input  logic [63:0] i_x_limb2,
    input  logic [63:0] i_x_limb3,
    input  logic [63:0] i_y_limb0,
    input  logic [63:0] i_y_limb1,
    input  logic [63:0] i_y_limb2,
    input  logic [63:0] i_y_limb3,
    output logic        o_valid,
    output logic [63:0] o_r_limb0,
    output logic [63:0] o_r_limb1,
    output logic [63:0] o_r_limb2,
    output logic [63:0] o_r_limb3
);
    import sm2mm_pkg::*;

    logic            r_v0;
    t_item           r_i0, n_i0;
    logic            v_chain [ROUNDS+1];
    t_item           i_chain [ROUNDS+1];
    logic [OP_W-1:0] result;
    logic            square;

    // The pipeline never refuses a request.
    assign busy = 1'b0;

    // Input register: select operands and modulus.
    assign square = (i_action == ACT_SQR_P);
    always_comb begin
        n_i0.x     = {i_x_limb3, i_x_limb2, i_x_limb1, i_x_limb0};
        n_i0.y     = square ? {i_x_limb3, i_x_limb2, i_x_limb1, i_x_limb0}
                            : {i_y_limb3, i_y_limb2, i_y_limb1, i_y_limb0};
        n_i0.n_sel = i_action[1];
        n_i0.acc   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i0 <= n_i0;
    end

    assign v_chain[0] = r_v0;
    assign i_chain[0] = r_i0;

    // Chain of Montgomery rounds, one 32-bit word each.
    for (genvar g = 0; g < ROUNDS; g++) begin : g_round
        sm2mm_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v_chain[g]),
            .i_item  (i_chain[g]),
            .o_valid (v_chain[g+1]),
            .o_item  (i_chain[g+1])
        );
    end

    // Final corrections and output register.
    sm2mm_final u_final (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (v_chain[ROUNDS]),
        .i_n_sel  (i_chain[ROUNDS].n_sel),
        .i_acc    (i_chain[ROUNDS].acc),
        .o_valid  (o_valid),
        .o_result (result)
    );

    assign o_r_limb0 = result[63:0];
    assign o_r_limb1 = result[127:64];
    assign o_r_limb2 = result[191:128];
    assign o_r_limb3 = result[255:192];

endmodule

[src/sm2mm_checker.sv]
// Port-level checker for the SM2 Montgomery multiplier, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sm2mm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  i_action,
    input logic        o_valid,
    input logic [63:0] o_r_limb0,
    input logic [63:0] o_r_limb1,
    input logic [63:0] o_r_limb2,
    input logic [63:0] o_r_limb3
);
    import sm2mm_pkg::*;

    // The pipeline takes a request in every cycle.
    `ASSERT_CLK_RST(a_never_busy, i_clk, i_rst_n, busy == 1'b0, "busy raised")

    // Every result strobe goes back to a request taken a fixed latency earlier.
    `ASSERT_CLK_RST(a_result_has_request, i_clk, i_rst_n,
        o_valid |-> $past(start && !busy, LATENCY), "result without request")

    // A result for the field prime is fully reduced.
    `ASSERT_CLK_RST(a_result_below_p, i_clk, i_rst_n,
        (o_valid && !$past(i_action[1], LATENCY)) |->
            ({o_r_limb3, o_r_limb2, o_r_limb1, o_r_limb0} < MOD_P),
        "result not below p")

    // No result leaves in the cycle after reset is held.
    `ASSERT_CLK(a_reset_clears, i_clk, $past(!i_rst_n) |-> !o_valid, "result after reset")

endmodule

bind sm2_montgomery_multiplier sm2mm_checker u_sm2mm_checker (.*);

[dv/tb.sv]
// Self-checking testbench for the pipelined SM2 Montgomery multiplier.
`timescale 1ns / 1ps
module tb;
    import sm2mm_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_action;
    logic [63:0] i_x_limb0, i_x_limb1, i_x_limb2, i_x_limb3;
    logic [63:0] i_y_limb0, i_y_limb1, i_y_limb2, i_y_limb3;
    logic        o_valid;
    logic [63:0] o_r_limb0, o_r_limb1, o_r_limb2, o_r_limb3;

    logic [255:0] product_q[$];
    int           cycles;
    bit           failed;
    int           idle_pct;

    sm2_montgomery_multiplier dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_action(i_action),
        .i_x_limb0(i_x_limb0), .i_x_limb1(i_x_limb1),
        .i_x_limb2(i_x_limb2), .i_x_limb3(i_x_limb3),
        .i_y_limb0(i_y_limb0), .i_y_limb1(i_y_limb1),
        .i_y_limb2(i_y_limb2), .i_y_limb3(i_y_limb3),
        .o_valid(o_valid),
        .o_r_limb0(o_r_limb0), .o_r_limb1(o_r_limb1),
        .o_r_limb2(o_r_limb2), .o_r_limb3(o_r_limb3)
    );

    // Clock with a 2 ns period.
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Negated inverse of the low modulus word modulo 2^64.
    function automatic logic [63:0] word_neg_inverse(input logic [63:0] m0);
        logic [63:0] inv;
        inv = m0;
        for (int k = 0; k < 6; k++) begin
            inv = inv * (64'd2 - m0 * inv);
        end
        return 64'd0 - inv;
    endfunction

    // Montgomery product x*y*2^-256 with 64-bit reduction rounds and two corrections.
    function automatic logic [255:0] mont_product(input logic [1:0] act,
                                                  input logic [255:0] x,
                                                  input logic [255:0] y);
        logic [255:0] m;
        logic [255:0] yy;
        logic [575:0] acc;
        logic [63:0]  q;
        logic [63:0]  ninv;
        logic [255:0] r;
        m    = act[1] ? MOD_N : MOD_P;
        yy   = (act == ACT_SQR_P) ? x : y;
        ninv = word_neg_inverse(m[63:0]);
        acc  = {320'd0, x} * {320'd0, yy};
        for (int i = 0; i < 4; i++) begin
            q   = acc[64*i +: 64] * ninv;
            acc = acc + (({512'd0, q} * {320'd0, m}) << (64 * i));
        end
        r = acc[511:256];
        if (acc[575:512] != 64'd0) r = r - m;
        if (r >= m) r = r - m;
        return r;
    endfunction

    // Send one request, honoring the sender idle rate and busy.
    task automatic send_request(input logic [1:0] act, input logic [255:0] x,
                                input logic [255:0] y);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start     <= 1'b1;
        i_action  <= act;
        {i_x_limb3, i_x_limb2, i_x_limb1, i_x_limb0} <= x;
        {i_y_limb3, i_y_limb2, i_y_limb1, i_y_limb0} <= y;
        forever begin
            @(negedge i_clk);
            if (!busy) break;
            @(posedge i_clk);
        end
        @(posedge i_clk);
        product_q.push_back(mont_product(act, x, y));
    endtask

    function automatic logic [255:0] rand_word256();
        return {$urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom};
    endfunction

    // Operand mix: full random, near a modulus, small, near all-ones, and sparse patterns.
    function automatic logic [255:0] rand_operand();
        logic [255:0] v;
        v = rand_word256();
        case ($urandom_range(5))
            0: v = MOD_P - {224'd0, $urandom};
            1: v = MOD_N + {224'd0, $urandom};
            2: v = {224'd0, $urandom};
            3: v = ~{224'd0, $urandom};
            4: v = v & rand_word256() & rand_word256();
            default: ;
        endcase
        return v;
    endfunction

    // Operand extremes, every action, the unused action code and squaring.
    task automatic test_directed();
        logic [255:0] ones;
        ones = '1;
        idle_pct = 0;
        for (int a = 0; a < 4; a++) begin
            send_request(a[1:0], '0, '0);
            send_request(a[1:0], ones, ones);
            send_request(a[1:0], MOD_P, ones);
            send_request(a[1:0], MOD_N - 256'd1, MOD_N - 256'd1);
            send_request(a[1:0], 256'd1, 256'd1);
        end
        send_request(ACT_SQR_P, MOD_P - 256'd1, rand_word256());
        send_request(ACT_SQR_P, ones, '0);
        send_request(ACT_MUL_N, MOD_N, MOD_N);
    endtask

    task automatic test_random(input int pct, input int count);
        idle_pct = pct;
        repeat (count) begin
            send_request(2'($urandom_range(3)), rand_operand(), rand_operand());
        end
    endtask

    // Compare each result strobe with the oldest expected product.
    always @(posedge i_clk) begin
        logic [255:0] want;
        logic [255:0] got;
        if (i_rst_n && o_valid) begin
            got = {o_r_limb3, o_r_limb2, o_r_limb1, o_r_limb0};
            if (product_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                failed = 1'b1;
            end else begin
                want = product_q.pop_front();
                if (got != want) begin
                    $display("%0t: mismatch expected %h actual %h", $time, want, got);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        cycles    = 0;
        failed    = 1'b0;
        idle_pct  = 0;
        i_rst_n   = 1'b0;
        start     = 1'b0;
        i_action  = ACT_MUL_P;
        {i_x_limb3, i_x_limb2, i_x_limb1, i_x_limb0} = '0;
        {i_y_limb3, i_y_limb2, i_y_limb1, i_y_limb0} = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(31, 460);
        test_random(85, 460);
        test_random(0, 460);
        start <= 1'b0;

        while (product_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
        if (!failed) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
